### rtl/tter_pkg.sv
// ----------------------------------------------------------------------------
// tter_pkg
// Shared types, widths and constants of the tile edge-function rasterizer.
// ----------------------------------------------------------------------------
`default_nettype none

package tter_pkg;

  localparam int TILE_SIZE_DEF     = 8;
  localparam int SUBPIXEL_BITS_DEF = 4;

  localparam int VW    = 16;       // vertex field width
  localparam int DVW   = VW + 1;   // doubled vertex coordinate
  localparam int DW    = VW + 3;   // edge delta and its negation
  localparam int PAW   = 2 * DW;   // area partial product
  localparam int AAW   = PAW + 1;  // doubled area
  localparam int XW    = 12;       // pixel coordinate
  localparam int CLRW  = 32;
  localparam int TIDW  = 9;
  localparam int BUFW  = 13;

  localparam logic [BUFW-1:0] BUF_WIDTH_RST  = 13'd640;
  localparam logic [BUFW-1:0] BUF_HEIGHT_RST = 13'd480;

  typedef enum logic [0:0] {
    REG_BUFFER_WIDTH  = 1'b0,
    REG_BUFFER_HEIGHT = 1'b1
  } reg_idx_e;

  // input request, last member in the lowest bits
  typedef struct packed {
    logic [TIDW-1:0] tile_row;
    logic [TIDW-1:0] tile_col;
    logic [CLRW-1:0] color;
    logic [VW-1:0]   v2y;
    logic [VW-1:0]   v2x;
    logic [VW-1:0]   v1y;
    logic [VW-1:0]   v1x;
    logic [VW-1:0]   v0y;
    logic [VW-1:0]   v0x;
  } in_item_t;

  localparam int IN_ITEM_W   = $bits(in_item_t);
  localparam int IN_TDATA_W  = ((IN_ITEM_W + 7) / 8) * 8;

  typedef struct packed {
    logic [CLRW-1:0] color;
    logic [XW-1:0]   y;
    logic [XW-1:0]   x;
  } out_data_t;

  localparam int OUT_TDATA_W = $bits(out_data_t);

  // per-triangle geometry, doubled coordinates
  typedef struct packed {
    logic signed [DVW-1:0] ax;
    logic signed [DVW-1:0] ay;
    logic signed [DVW-1:0] bx;
    logic signed [DVW-1:0] by;
    logic signed [DVW-1:0] cx;
    logic signed [DVW-1:0] cy;
    logic signed [DW-1:0]  d0x;
    logic signed [DW-1:0]  nd0y;
    logic signed [DW-1:0]  d1x;
    logic signed [DW-1:0]  nd1y;
    logic signed [DW-1:0]  d2x;
    logic signed [DW-1:0]  nd2y;
  } tri_geom_t;

  typedef struct packed {
    tri_geom_t       geom;
    logic            live;
    logic            positive;
    logic [CLRW-1:0] color;
    logic [TIDW-1:0] tile_col;
    logic [TIDW-1:0] tile_row;
  } tri_setup_t;

  typedef struct packed {
    logic [XW-1:0]   x;
    logic [XW-1:0]   y;
    logic            ok;
    logic            positive;
    logic [CLRW-1:0] color;
    logic            last;
  } pix_meta_t;

endpackage

`default_nettype wire

### rtl/tter_setup.sv
// ----------------------------------------------------------------------------
// tter_setup
// Three-stage triangle setup: capture, edge deltas, area products and the
// degenerate / orientation decision.
// ----------------------------------------------------------------------------
`default_nettype none

module tter_setup #(
  parameter int SUBPIXEL_BITS = tter_pkg::SUBPIXEL_BITS_DEF
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              in_valid_i,
  output logic                             in_ready_o,
  input  wire  [tter_pkg::IN_ITEM_W-1:0]   in_data_i,
  output logic                             out_valid_o,
  input  wire                              out_ready_i,
  output tter_pkg::tri_setup_t             out_setup_o
);
  import tter_pkg::*;

  localparam longint LIMIT_I = longint'(1) << (2 * SUBPIXEL_BITS + 1);
  localparam logic signed [AAW-1:0] LIM_P = AAW'(LIMIT_I);
  localparam logic signed [AAW-1:0] LIM_N = -LIM_P;

  in_item_t   s1_q;
  tri_setup_t s2_q, s2_d;
  tri_setup_t s3_q;
  logic signed [PAW-1:0] pa_q, pb_q;
  logic v1_q, v2_q, v3_q;
  logic rdy1, rdy2, rdy3;
  logic signed [DVW-1:0] ax, ay, bx, by, cx, cy;
  logic signed [AAW-1:0] area;

  assign rdy3       = !v3_q || out_ready_i;
  assign rdy2       = !v2_q || rdy3;
  assign rdy1       = !v1_q || rdy2;
  assign in_ready_o = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  always_comb begin
    ax = $signed({s1_q.v0x, 1'b0});
    ay = $signed({s1_q.v0y, 1'b0});
    bx = $signed({s1_q.v1x, 1'b0});
    by = $signed({s1_q.v1y, 1'b0});
    cx = $signed({s1_q.v2x, 1'b0});
    cy = $signed({s1_q.v2y, 1'b0});
    s2_d           = '0;
    s2_d.geom.ax   = ax;
    s2_d.geom.ay   = ay;
    s2_d.geom.bx   = bx;
    s2_d.geom.by   = by;
    s2_d.geom.cx   = cx;
    s2_d.geom.cy   = cy;
    s2_d.geom.d0x  = DW'(bx) - DW'(ax);
    s2_d.geom.nd0y = DW'(ay) - DW'(by);
    s2_d.geom.d1x  = DW'(cx) - DW'(bx);
    s2_d.geom.nd1y = DW'(by) - DW'(cy);
    s2_d.geom.d2x  = DW'(ax) - DW'(cx);
    s2_d.geom.nd2y = DW'(cy) - DW'(ay);
    s2_d.color     = s1_q.color;
    s2_d.tile_col  = s1_q.tile_col;
    s2_d.tile_row  = s1_q.tile_row;
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && rdy1) s1_q <= in_item_t'(in_data_i);
    if (v1_q && rdy2) s2_q <= s2_d;
    if (v2_q && rdy3) begin
      s3_q <= s2_q;
      pa_q <= s2_q.geom.nd0y * s2_q.geom.d2x;
      pb_q <= s2_q.geom.d0x * s2_q.geom.nd2y;
    end
  end

  // doubled area is four times the subpixel area
  assign area = AAW'(pa_q) - AAW'(pb_q);

  always_comb begin
    out_setup_o          = s3_q;
    out_setup_o.live     = (area >= LIM_P) || (area <= LIM_N);
    out_setup_o.positive = area > 0;
  end

  assign out_valid_o = v3_q;

endmodule

`default_nettype wire

### rtl/tter_walker.sv
// ----------------------------------------------------------------------------
// tter_walker
// Holds the current triangle and walks the tile row-major, one pixel per
// cycle while pix_ready_i is high, with buffer clipping.
// ----------------------------------------------------------------------------
`default_nettype none

module tter_walker #(
  parameter int TILE_SIZE = tter_pkg::TILE_SIZE_DEF
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           setup_valid_i,
  output logic                          setup_ready_o,
  input  tter_pkg::tri_setup_t          setup_i,
  input  wire  [tter_pkg::BUFW-1:0]     buf_width_i,
  input  wire  [tter_pkg::BUFW-1:0]     buf_height_i,
  output logic                          pix_valid_o,
  input  wire                           pix_ready_i,
  output tter_pkg::pix_meta_t           pix_meta_o,
  output tter_pkg::tri_geom_t           pix_geom_o
);
  import tter_pkg::*;

  localparam int CTRW = $clog2(TILE_SIZE);
  localparam logic [CTRW-1:0] MAXC = CTRW'(TILE_SIZE - 1);

  tri_setup_t cur_q;
  logic have_q;
  logic [CTRW-1:0] col_q, row_q;
  logic is_last, fire, load;
  logic [XW-1:0] x, y;

  assign is_last       = (col_q == MAXC) && (row_q == MAXC);
  assign fire          = have_q && pix_ready_i;
  assign setup_ready_o = !have_q || (fire && is_last);
  assign load          = setup_valid_i && setup_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q <= 1'b0;
      col_q  <= '0;
      row_q  <= '0;
    end else begin
      if (load) begin
        have_q <= 1'b1;
      end else if (fire && is_last) begin
        have_q <= 1'b0;
      end
      if (fire) begin
        if (col_q == MAXC) begin
          col_q <= '0;
          row_q <= is_last ? '0 : row_q + 1'b1;
        end else begin
          col_q <= col_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) cur_q <= setup_i;
  end

  assign x = XW'(cur_q.tile_col * TILE_SIZE) + XW'(col_q);
  assign y = XW'(cur_q.tile_row * TILE_SIZE) + XW'(row_q);

  always_comb begin
    pix_meta_o.x        = x;
    pix_meta_o.y        = y;
    pix_meta_o.ok       = cur_q.live && ({1'b0, x} < buf_width_i)
                          && ({1'b0, y} < buf_height_i);
    pix_meta_o.positive = cur_q.positive;
    pix_meta_o.color    = cur_q.color;
    pix_meta_o.last     = is_last;
  end

  assign pix_geom_o  = cur_q.geom;
  assign pix_valid_o = have_q;

endmodule

`default_nettype wire

### rtl/tter_edge.sv
// ----------------------------------------------------------------------------
// tter_edge
// Edge-function pipeline: center offsets, products, sums and sign test,
// then the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tter_edge #(
  parameter int SUBPIXEL_BITS = tter_pkg::SUBPIXEL_BITS_DEF
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               in_valid_i,
  output logic                              in_ready_o,
  input  tter_pkg::pix_meta_t               in_meta_i,
  input  tter_pkg::tri_geom_t               in_geom_i,
  output logic                              m_valid_o,
  input  wire                               m_ready_i,
  output logic [tter_pkg::OUT_TDATA_W-1:0]  m_data_o,
  output logic                              m_we_o,
  output logic                              m_last_o
);
  import tter_pkg::*;

  localparam int PXW = XW + 1 + SUBPIXEL_BITS;
  localparam int CW  = ((PXW + 1 > DVW) ? PXW + 1 : DVW) + 1;
  localparam int PW  = CW + DW;
  localparam int WW  = PW + 1;

  pix_meta_t m1_q, m2_q;
  logic v1_q, v2_q, v3_q;
  logic rdy1, rdy2, rdy3;
  logic signed [CW-1:0] ex_q [3];
  logic signed [CW-1:0] ey_q [3];
  logic signed [DW-1:0] dx_q [3];
  logic signed [DW-1:0] ndy_q [3];
  logic signed [PW-1:0] pa_q [3];
  logic signed [PW-1:0] pb_q [3];
  logic signed [CW-1:0] px_s, py_s;
  logic signed [CW-1:0] vx [3];
  logic signed [CW-1:0] vy [3];
  logic signed [DW-1:0] dx [3];
  logic signed [DW-1:0] ndy [3];
  logic signed [WW-1:0] w [3];
  logic all_ge, all_le, we;
  out_data_t data_q;
  logic we_q, last_q;

  assign rdy3       = !v3_q || m_ready_i;
  assign rdy2       = !v2_q || rdy3;
  assign rdy1       = !v1_q || rdy2;
  assign in_ready_o = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  // pixel center in doubled subpixel units: (2x+1) << SUBPIXEL_BITS
  always_comb begin
    px_s = $signed(CW'(PXW'({in_meta_i.x, 1'b1}) << SUBPIXEL_BITS));
    py_s = $signed(CW'(PXW'({in_meta_i.y, 1'b1}) << SUBPIXEL_BITS));
    vx[0]  = CW'(in_geom_i.bx);
    vy[0]  = CW'(in_geom_i.by);
    vx[1]  = CW'(in_geom_i.cx);
    vy[1]  = CW'(in_geom_i.cy);
    vx[2]  = CW'(in_geom_i.ax);
    vy[2]  = CW'(in_geom_i.ay);
    dx[0]  = in_geom_i.d0x;
    ndy[0] = in_geom_i.nd0y;
    dx[1]  = in_geom_i.d1x;
    ndy[1] = in_geom_i.nd1y;
    dx[2]  = in_geom_i.d2x;
    ndy[2] = in_geom_i.nd2y;
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && rdy1) begin
      m1_q <= in_meta_i;
      for (int i = 0; i < 3; i++) begin
        ex_q[i]  <= px_s - vx[i];
        ey_q[i]  <= py_s - vy[i];
        dx_q[i]  <= dx[i];
        ndy_q[i] <= ndy[i];
      end
    end
    if (v1_q && rdy2) begin
      m2_q <= m1_q;
      for (int i = 0; i < 3; i++) begin
        pa_q[i] <= ex_q[i] * ndy_q[i];
        pb_q[i] <= ey_q[i] * dx_q[i];
      end
    end
    if (v2_q && rdy3) begin
      data_q.x     <= m2_q.x;
      data_q.y     <= m2_q.y;
      data_q.color <= m2_q.color;
      we_q         <= we;
      last_q       <= m2_q.last;
    end
  end

  always_comb begin
    all_ge = 1'b1;
    all_le = 1'b1;
    for (int i = 0; i < 3; i++) begin
      w[i] = WW'(pa_q[i]) + WW'(pb_q[i]);
      if (w[i] < 0) all_ge = 1'b0;
      if (w[i] > 0) all_le = 1'b0;
    end
    we = m2_q.ok && (m2_q.positive ? all_ge : all_le);
  end

  assign m_valid_o = v3_q;
  assign m_data_o  = data_q;
  assign m_we_o    = we_q;
  assign m_last_o  = last_q;

endmodule

`default_nettype wire

### rtl/triangle_tile_edge_rasterizer.sv
// ----------------------------------------------------------------------------
// triangle_tile_edge_rasterizer
// Edge-function rasterizer: one triangle request in, TILE_SIZE^2 pixel
// requests of one tile out, row-major, clipped to the buffer.
// ----------------------------------------------------------------------------
// Flow: a triangle passes the setup stages and the walker register, and each
// pixel the edge stages. Pixels leave one per cycle while m_axis_tready is
// high, set by the single-issue tile walker; the setup of the next triangle
// overlaps the walk of the current one.
// Reset: pipeline valids and walker counters clear; buffer size returns to
// 640 x 480.
`default_nettype none

module triangle_tile_edge_rasterizer #(
  parameter int TILE_SIZE     = tter_pkg::TILE_SIZE_DEF,
  parameter int SUBPIXEL_BITS = tter_pkg::SUBPIXEL_BITS_DEF
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  // v0x, v0y, v1x, v1y, v2x, v2y, color, tile_col, tile_row, zero pad
  input  wire  [tter_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  input  wire                               s_axis_tvalid,
  output logic                              s_axis_tready,
  // pixel_x, pixel_y, pixel_color
  output logic [tter_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  // write_enable
  output logic                              m_axis_tuser,
  output logic                              m_axis_tlast,
  output logic                              m_axis_tvalid,
  input  wire                               m_axis_tready,
  input  wire                               cfg_we_i,
  input  wire                               cfg_addr_i,
  input  wire  [tter_pkg::BUFW-1:0]         cfg_wdata_i
);
  import tter_pkg::*;

  logic [BUFW-1:0] buf_width_q, buf_height_q;
  logic setup_valid, setup_ready;
  tri_setup_t setup;
  logic pix_valid, pix_ready;
  pix_meta_t pix_meta;
  tri_geom_t pix_geom;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_width_q  <= BUF_WIDTH_RST;
      buf_height_q <= BUF_HEIGHT_RST;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_addr_i))
        REG_BUFFER_WIDTH:  buf_width_q  <= cfg_wdata_i;
        REG_BUFFER_HEIGHT: buf_height_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  tter_setup #(
    .SUBPIXEL_BITS(SUBPIXEL_BITS)
  ) u_setup (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_data_i  (s_axis_tdata[IN_ITEM_W-1:0]),
    .out_valid_o(setup_valid),
    .out_ready_i(setup_ready),
    .out_setup_o(setup)
  );

  tter_walker #(
    .TILE_SIZE(TILE_SIZE)
  ) u_walker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .setup_valid_i(setup_valid),
    .setup_ready_o(setup_ready),
    .setup_i      (setup),
    .buf_width_i  (buf_width_q),
    .buf_height_i (buf_height_q),
    .pix_valid_o  (pix_valid),
    .pix_ready_i  (pix_ready),
    .pix_meta_o   (pix_meta),
    .pix_geom_o   (pix_geom)
  );

  tter_edge #(
    .SUBPIXEL_BITS(SUBPIXEL_BITS)
  ) u_edge (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(pix_valid),
    .in_ready_o(pix_ready),
    .in_meta_i (pix_meta),
    .in_geom_i (pix_geom),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_data_o  (m_axis_tdata),
    .m_we_o    (m_axis_tuser),
    .m_last_o  (m_axis_tlast)
  );

endmodule

`default_nettype wire

### verif/tter_checker.sv
// ----------------------------------------------------------------------------
// tter_checker
// Watches the triangle, pixel and register ports of the rasterizer. It keeps
// its own copy of the buffer size, computes the 64 expected pixels of every
// accepted triangle request and compares each accepted pixel with them.
// ----------------------------------------------------------------------------
`default_nettype none

module tter_checker (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire  [tter_pkg::IN_TDATA_W-1:0]   s_tdata_i,
  input  wire                               s_tvalid_i,
  input  wire                               s_tready_i,
  input  wire  [tter_pkg::OUT_TDATA_W-1:0]  m_tdata_i,
  input  wire                               m_tuser_i,
  input  wire                               m_tlast_i,
  input  wire                               m_tvalid_i,
  input  wire                               m_tready_i,
  input  wire                               cfg_we_i,
  input  wire                               cfg_addr_i,
  input  wire  [tter_pkg::BUFW-1:0]         cfg_wdata_i,
  output int                                pending_o,
  output int                                errors_o
);
  import tter_pkg::*;

  localparam int TILE = TILE_SIZE_DEF;
  localparam int SUB  = SUBPIXEL_BITS_DEF;

  typedef struct {
    logic [XW-1:0]   x;
    logic [XW-1:0]   y;
    logic            we;
    logic [CLRW-1:0] color;
    logic            last;
  } pixel_t;

  pixel_t          pixel_q[$];
  logic [BUFW-1:0] buf_w;
  logic [BUFW-1:0] buf_h;
  out_data_t       seen;
  pixel_t          want;

  task automatic report(input string msg);
    errors_o++;
    $display("mismatch at %0t: %s", $time, msg);
  endtask

  // expected pixels of one tile, row-major
  function automatic void predict_tile_pixels(input in_item_t it);
    longint ax, ay, bx, by, cx, cy;
    longint d0x, d0y, d1x, d1y, d2x, d2y;
    longint area4, mag, bx0, by0, x, y, px, py, w0, w1, w2;
    bit     flat, pos, hit;
    pixel_t p;
    ax = 2 * longint'($signed(it.v0x));
    ay = 2 * longint'($signed(it.v0y));
    bx = 2 * longint'($signed(it.v1x));
    by = 2 * longint'($signed(it.v1y));
    cx = 2 * longint'($signed(it.v2x));
    cy = 2 * longint'($signed(it.v2y));
    d0x = bx - ax; d0y = by - ay;
    d1x = cx - bx; d1y = cy - by;
    d2x = ax - cx; d2y = ay - cy;
    area4 = d0x * d2y - d0y * d2x;
    mag   = (area4 < 0) ? -area4 : area4;
    // doubled coordinates: half a square pixel is 2 * 4^SUB
    flat  = mag < (longint'(1) << (2 * SUB + 1));
    pos   = area4 > 0;
    bx0   = longint'(it.tile_col) * TILE;
    by0   = longint'(it.tile_row) * TILE;
    for (int k = 0; k < TILE * TILE; k++) begin
      x   = bx0 + k % TILE;
      y   = by0 + k / TILE;
      hit = 1'b0;
      if (!flat && x < longint'(buf_w) && y < longint'(buf_h)) begin
        px = (2 * x + 1) * (longint'(1) << SUB);
        py = (2 * y + 1) * (longint'(1) << SUB);
        w0 = (px - bx) * (-d0y) + (py - by) * d0x;
        w1 = (px - cx) * (-d1y) + (py - cy) * d1x;
        w2 = (px - ax) * (-d2y) + (py - ay) * d2x;
        if (pos) hit = (w0 >= 0) && (w1 >= 0) && (w2 >= 0);
        else     hit = (w0 <= 0) && (w1 <= 0) && (w2 <= 0);
      end
      p.x     = x[XW-1:0];
      p.y     = y[XW-1:0];
      p.we    = hit;
      p.color = it.color;
      p.last  = (k == TILE * TILE - 1);
      pixel_q.push_back(p);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_w = BUF_WIDTH_RST;
      buf_h = BUF_HEIGHT_RST;
      pixel_q.delete();
      pending_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (reg_idx_e'(cfg_addr_i))
          REG_BUFFER_WIDTH:  buf_w = cfg_wdata_i;
          REG_BUFFER_HEIGHT: buf_h = cfg_wdata_i;
          default: ;
        endcase
      end
      if (s_tvalid_i && s_tready_i)
        predict_tile_pixels(in_item_t'(s_tdata_i[IN_ITEM_W-1:0]));
      if (m_tvalid_i && m_tready_i) begin
        seen = out_data_t'(m_tdata_i);
        if (pixel_q.size() == 0) begin
          report($sformatf("pixel (%0d,%0d) with nothing pending", seen.x, seen.y));
        end else begin
          want = pixel_q.pop_front();
          if (seen.x !== want.x)
            report($sformatf("pixel_x %0d, want %0d", seen.x, want.x));
          if (seen.y !== want.y)
            report($sformatf("pixel_y %0d, want %0d", seen.y, want.y));
          if (m_tuser_i !== want.we)
            report($sformatf("write_enable %b at (%0d,%0d), want %b",
                             m_tuser_i, want.x, want.y, want.we));
          if (seen.color !== want.color)
            report($sformatf("pixel_color %h, want %h", seen.color, want.color));
          if (m_tlast_i !== want.last)
            report($sformatf("last_pixel %b at (%0d,%0d), want %b",
                             m_tlast_i, want.x, want.y, want.last));
        end
      end
      pending_o = pixel_q.size();
    end
  end

endmodule

`default_nettype wire

### verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the tile rasterizer: directed triangles (orientation, edge
// cases, degenerate area, clipping, field extremes), then random triangles,
// most placed around their tile, under several buffer sizes, with random bursts of
// idle cycles on both streams. Checking lives in tter_checker.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import tter_pkg::*;

  localparam int LIMIT = 400000;

  logic                   clk_i;
  logic                   rst_ni;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tuser;
  logic                   m_axis_tlast;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic                   cfg_we_i;
  logic                   cfg_addr_i;
  logic [BUFW-1:0]        cfg_wdata_i;

  int pending;
  int errors;
  int cycles;
  int stall_left;
  bit calm;

  triangle_tile_edge_rasterizer DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  tter_checker u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tdata_i  (s_axis_tdata),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_i (s_axis_tready),
    .m_tdata_i  (m_axis_tdata),
    .m_tuser_i  (m_axis_tuser),
    .m_tlast_i  (m_axis_tlast),
    .m_tvalid_i (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .cfg_we_i   (cfg_we_i),
    .cfg_addr_i (cfg_addr_i),
    .cfg_wdata_i(cfg_wdata_i),
    .pending_o  (pending),
    .errors_o   (errors)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // pixel sink: stalls in random bursts
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 2);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  function automatic logic [15:0] clamp16(input int v);
    if (v > 32767) return 16'h7fff;
    if (v < -32768) return 16'h8000;
    return v[15:0];
  endfunction

  task automatic send_tri(input int ax, input int ay, input int bx, input int by,
                          input int cx, input int cy, input logic [31:0] color,
                          input int col, input int row);
    in_item_t it;
    int       gap;
    it.v0x      = clamp16(ax);
    it.v0y      = clamp16(ay);
    it.v1x      = clamp16(bx);
    it.v1y      = clamp16(by);
    it.v2x      = clamp16(cx);
    it.v2y      = clamp16(cy);
    it.color    = color;
    it.tile_col = col[TIDW-1:0];
    it.tile_row = row[TIDW-1:0];
    @(negedge clk_i);
    if (!calm && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 3);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tdata  <= IN_TDATA_W'(it);
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // drop the request line and wait for every pending pixel
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic set_buffer(input int w, input int h);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= REG_BUFFER_WIDTH;
    cfg_wdata_i <= w[BUFW-1:0];
    @(negedge clk_i);
    cfg_addr_i  <= REG_BUFFER_HEIGHT;
    cfg_wdata_i <= h[BUFW-1:0];
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic run_phase(input int w, input int h, input int n, input bit ending);
    int max_col, max_row, col, row, cenx, ceny, spread, mode, dx, dy;
    int v[6];
    set_buffer(w, h);
    // tiles reach a little past the buffer edge; vertices cannot go past 2047 px
    max_col = (w + 7) / 8 + 1;
    max_row = (h + 7) / 8 + 1;
    if (max_col > 260) max_col = 260;
    if (max_row > 260) max_row = 260;
    for (int i = 0; i < n; i++) begin
      calm = ending && (i >= n - 40);
      mode = $urandom_range(0, 9);
      col  = $urandom_range(0, max_col);
      row  = $urandom_range(0, max_row);
      cenx = col * 128 + 64;
      ceny = row * 128 + 64;
      if (mode == 7) begin
        foreach (v[j]) v[j] = int'($urandom_range(0, 65535)) - 32768;
        col = $urandom_range(0, 511);
        row = $urandom_range(0, 511);
      end else if (mode >= 8) begin
        // nearly collinear, sliver or below the area threshold
        dx   = int'($urandom_range(0, 128)) - 64;
        dy   = int'($urandom_range(0, 128)) - 64;
        v[0] = cenx + int'($urandom_range(0, 256)) - 128;
        v[1] = ceny + int'($urandom_range(0, 256)) - 128;
        v[2] = v[0] + dx;
        v[3] = v[1] + dy;
        v[4] = v[0] + 2 * dx + int'($urandom_range(0, 2)) - 1;
        v[5] = v[1] + 2 * dy + int'($urandom_range(0, 2)) - 1;
      end else begin
        spread = ($urandom_range(0, 3) == 0) ? 2048 : 320;
        for (int j = 0; j < 6; j += 2) begin
          v[j]   = cenx + int'($urandom_range(0, 2 * spread)) - spread;
          v[j+1] = ceny + int'($urandom_range(0, 2 * spread)) - spread;
        end
      end
      send_tri(v[0], v[1], v[2], v[3], v[4], v[5], $urandom, col, row);
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tvalid = 1'b0;
    m_axis_tready = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_addr_i    = REG_BUFFER_WIDTH;
    cfg_wdata_i   = '0;
    cycles        = 0;
    stall_left    = 0;
    calm          = 1'b0;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed, buffer at its reset size of 640 x 480 (1 px = 16 units)
    send_tri(0, 0, 128, 0, 0, 128, 32'h0000_0000, 0, 0);
    send_tri(0, 0, 0, 128, 128, 0, 32'hffff_ffff, 0, 0);
    send_tri(0, 0, 64, 64, 128, 128, 32'h1234_5678, 0, 0);      // collinear
    send_tri(0, 0, 127, 0, 0, 1, 32'h0000_0001, 0, 0);          // just under half px
    send_tri(0, 0, 128, 0, 0, 1, 32'h8000_0000, 0, 0);          // exactly half px
    send_tri(8, 8, 120, 8, 8, 120, 32'h0f0f_3c3c, 0, 0);        // edges on centers
    send_tri(8, 8, 8, 120, 120, 8, 32'hf0f0_c3c3, 0, 0);
    send_tri(-32768, -32768, 32767, -32768, -32768, 32767, 32'ha5a5_a5a5, 0, 0);
    send_tri(-32768, -32768, 32767, 32767, 32767, -32768, 32'h5a5a_5a5a, 79, 59);
    send_tri(32767, 32767, 32767, 32767, 32767, 32767, 32'h7fff_ffff, 511, 511);
    send_tri(-32768, -32768, -32768, -32768, -32768, -32768, 32'h0000_ffff, 0, 0);
    send_tri(-32768, -32768, 32767, -32768, 32767, 32767, 32'hffff_0000, 80, 0);
    send_tri(-32768, -32768, 32767, -32768, 32767, 32767, 32'h00ff_00ff, 0, 60);
    send_tri(-32768, -32768, 32767, -32768, 32767, 32767, 32'hff00_ff00, 511, 511);
    send_tri(20, 10, 110, 40, 50, 125, 32'h3c3c_0f0f, 0, 0);
    send_tri(-40, -40, 200, 30, 30, 200, 32'h6699_aa55, 0, 0);
    send_tri(130, 130, 150, 130, 130, 150, 32'h9966_55aa, 1, 1); // less than one pixel of area

    run_phase(4096, 4096, 60, 1'b0);
    run_phase(1, 1, 20, 1'b0);
    run_phase(0, 8191, 20, 1'b0);
    run_phase(8191, 0, 20, 1'b0);
    run_phase($urandom_range(1, 300), $urandom_range(1, 300), 60, 1'b0);
    run_phase(640, 480, 90, 1'b1);

    drain();
    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

### files.f
rtl/tter_pkg.sv
rtl/tter_setup.sv
rtl/tter_walker.sv
rtl/tter_edge.sv
rtl/triangle_tile_edge_rasterizer.sv
verif/tter_checker.sv
verif/tb_top.sv
